FILE: design/itoa_pkg.sv
package itoa_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int DIGIT_SLOTS = 32;
    localparam int SLOT_BITS   = $clog2(DIGIT_SLOTS);
    localparam int CNT_BITS    = $clog2(DIGIT_SLOTS + 1);
    localparam int RADIX_BITS  = 6;
    localparam int LIMIT_BITS  = 7;
    localparam int CHAR_BITS   = 7;
    localparam int DIGIT_BITS  = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [0:0] CFG_RADIX = 1'b0;
    localparam logic [0:0] CFG_LIMIT = 1'b1;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_ALPHA = 7'h37;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'h2d;

    // classified job handed from front to back
    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic                  neg;
        logic [CNT_BITS-1:0]   lim;
    } itoa_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_RDREQ,
        ST_EMIT
    } itoa_state_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        if (d < DIGIT_BITS'(10)) begin
            return CHAR_ZERO + CHAR_BITS'(d);
        end
        return CHAR_ALPHA + CHAR_BITS'(d);
    endfunction

endpackage

FILE: design/itoa_ram.sv
module itoa_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/itoa_front.sv
module itoa_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [itoa_pkg::VALUE_BITS-1:0]     s_value,
    input  logic                                s_is_signed,
    input  logic [itoa_pkg::LIMIT_BITS-1:0]     limit,
    output logic                                job_valid,
    input  logic                                job_ready,
    output itoa_pkg::itoa_job_t                 job
);
    localparam int PTR_BITS = $clog2(itoa_pkg::QUEUE_DEPTH);

    itoa_pkg::itoa_job_t q_reg [itoa_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, rd_reg;
    logic [PTR_BITS:0]   cnt_reg;
    itoa_pkg::itoa_job_t cls;
    logic [itoa_pkg::LIMIT_BITS-1:0] lim_w;
    logic push, pop;

    always_comb begin
        cls.neg = s_is_signed & s_value[itoa_pkg::VALUE_BITS-1];
        cls.mag = cls.neg ? (~s_value + 1'b1) : s_value;
        lim_w   = limit;
        if (cls.neg && lim_w != '0) begin
            lim_w = lim_w - 1'b1;
        end
        if (lim_w == '0) begin
            lim_w = itoa_pkg::LIMIT_BITS'(1);
        end
        if (lim_w > itoa_pkg::LIMIT_BITS'(itoa_pkg::DIGIT_SLOTS)) begin
            lim_w = itoa_pkg::LIMIT_BITS'(itoa_pkg::DIGIT_SLOTS);
        end
        cls.lim = itoa_pkg::CNT_BITS'(lim_w);
    end

    assign s_ready   = (cnt_reg != (PTR_BITS+1)'(itoa_pkg::QUEUE_DEPTH));
    assign job_valid = (cnt_reg != '0);
    assign job       = q_reg[rd_reg];
    assign push      = s_valid & s_ready;
    assign pop       = job_valid & job_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= cls;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
        end
    end
endmodule

FILE: design/itoa_back.sv
module itoa_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               job_valid,
    output logic                               job_ready,
    input  itoa_pkg::itoa_job_t                job,
    input  logic [itoa_pkg::RADIX_BITS-1:0]    radix,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [itoa_pkg::CHAR_BITS-1:0]     m_char_code,
    output logic                               m_last
);
    localparam int VB = itoa_pkg::VALUE_BITS;
    localparam int SB = itoa_pkg::SLOT_BITS;
    localparam int CB = itoa_pkg::CNT_BITS;
    localparam int DB = itoa_pkg::DIGIT_BITS;
    localparam int BB = $clog2(VB);

    itoa_pkg::itoa_state_t state_reg, state_next;

    logic [VB-1:0] quot_reg, quot_next;
    logic [DB-1:0] rem_reg, rem_next;
    logic [BB-1:0] bit_reg, bit_next;
    logic [CB-1:0] n_reg, n_next, lim_reg, lim_next;
    logic          neg_reg, neg_next;
    logic          out_v_reg, out_v_next;
    logic [itoa_pkg::CHAR_BITS-1:0] out_c_reg, out_c_next;
    logic          out_l_reg, out_l_next;

    logic          we;
    logic [SB-1:0] waddr, raddr;
    logic [DB-1:0] rdata;
    logic [DB:0]   trial;
    logic          ge;
    logic [DB-1:0] rem_w;
    logic          out_free;

    itoa_ram #(.WIDTH(DB), .DEPTH(itoa_pkg::DIGIT_SLOTS)) u_store (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(rem_w),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign m_valid     = out_v_reg;
    assign m_char_code = out_c_reg;
    assign m_last      = out_l_reg;
    assign out_free    = !out_v_reg || m_ready;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quot_reg[VB-1]};
    assign ge    = trial >= {1'b0, radix};
    assign rem_w = ge ? DB'(trial - {1'b0, radix}) : trial[DB-1:0];

    always_comb begin
        state_next = state_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        n_next     = n_reg;
        lim_next   = lim_reg;
        neg_next   = neg_reg;
        out_v_next = out_v_reg && !m_ready;
        out_c_next = out_c_reg;
        out_l_next = out_l_reg;
        job_ready  = 1'b0;
        we         = 1'b0;
        waddr      = SB'(n_reg);
        raddr      = SB'(n_reg - 1'b1);
        unique case (state_reg)
            itoa_pkg::ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    quot_next  = job.mag;
                    neg_next   = job.neg;
                    lim_next   = job.lim;
                    rem_next   = '0;
                    bit_next   = '0;
                    n_next     = '0;
                    state_next = itoa_pkg::ST_DIV;
                end
            end
            itoa_pkg::ST_DIV: begin
                rem_next  = rem_w;
                quot_next = {quot_reg[VB-2:0], ge};
                bit_next  = bit_reg + 1'b1;
                if (bit_reg == BB'(VB-1)) begin
                    // final remainder goes to the store, next digit starts from zero
                    we       = 1'b1;
                    n_next   = n_reg + 1'b1;
                    rem_next = '0;
                    bit_next = '0;
                    if ((n_reg + 1'b1) == lim_reg || quot_next == '0) begin
                        state_next = neg_reg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_RDREQ;
                    end
                end
            end
            itoa_pkg::ST_SIGN: begin
                if (out_free) begin
                    out_v_next = 1'b1;
                    out_c_next = itoa_pkg::CHAR_MINUS;
                    out_l_next = 1'b0;
                    state_next = itoa_pkg::ST_RDREQ;
                end
            end
            itoa_pkg::ST_RDREQ: begin
                state_next = itoa_pkg::ST_EMIT;
            end
            itoa_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_v_next = 1'b1;
                    out_c_next = itoa_pkg::digit_char(rdata);
                    out_l_next = (n_reg == CB'(1));
                    n_next     = n_reg - 1'b1;
                    state_next = (n_reg == CB'(1)) ? itoa_pkg::ST_IDLE : itoa_pkg::ST_RDREQ;
                end
            end
            default: state_next = itoa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        lim_reg   <= lim_next;
        neg_reg   <= neg_next;
        out_c_reg <= out_c_next;
        out_l_reg <= out_l_next;
        if (!aresetn) begin
            state_reg <= itoa_pkg::ST_IDLE;
            bit_reg   <= '0;
            n_reg     <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            n_reg     <= n_next;
            out_v_reg <= out_v_next;
        end
    end
endmodule

FILE: design/integer_to_radix_ascii.sv
// Channel | Ports                              | Transfer when
// s       | s_value, s_is_signed               | s_valid & s_ready
// m       | m_char_code, m_last                | m_valid & m_ready
// cfg     | cfg_we, cfg_index, cfg_wdata       | cfg_we (no wait)
//
// Each digit is produced by the shared one-bit-per-cycle divider; a word is handled
// in order: the job is taken, each digit is divided out and its remainder stored,
// then a sign if negative and the digits are emitted, most significant first.
// The two-entry job queue lets the input side run ahead while digits drain.
// aresetn is synchronous, active low; it clears queue and control state.
// A stalled m_ready holds the output register and pauses the emitter.
module integer_to_radix_ascii (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [itoa_pkg::VALUE_BITS-1:0]   s_value,
    input  logic                              s_is_signed,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [itoa_pkg::CHAR_BITS-1:0]    m_char_code,
    output logic                              m_last,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [itoa_pkg::LIMIT_BITS-1:0]   cfg_wdata
);
    logic [itoa_pkg::RADIX_BITS-1:0] radix_reg;
    logic [itoa_pkg::LIMIT_BITS-1:0] limit_reg;
    logic [itoa_pkg::RADIX_BITS-1:0] radix_w;
    logic                            job_valid, job_ready;
    itoa_pkg::itoa_job_t             job;

    // clamp radix writes to 2..36
    always_comb begin
        radix_w = cfg_wdata[itoa_pkg::RADIX_BITS-1:0];
        if (radix_w < itoa_pkg::RADIX_BITS'(2)) begin
            radix_w = itoa_pkg::RADIX_BITS'(2);
        end else if (radix_w > itoa_pkg::RADIX_BITS'(36)) begin
            radix_w = itoa_pkg::RADIX_BITS'(36);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= itoa_pkg::RADIX_BITS'(10);
            limit_reg <= itoa_pkg::LIMIT_BITS'(64);
        end else if (cfg_we) begin
            if (cfg_index == itoa_pkg::CFG_RADIX) begin
                radix_reg <= radix_w;
            end else if (cfg_index == itoa_pkg::CFG_LIMIT) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    itoa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_is_signed(s_is_signed),
        .limit      (limit_reg),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    itoa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .radix      (radix_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_char_code(m_char_code),
        .m_last     (m_last)
    );
endmodule
